// ===== hw/rtl/eac3_aus_pkg.sv =====
// Shared types, codes and header tables for the E-AC-3 access unit start checker.
package eac3_aus_pkg;

  localparam int BYTE_W            = 8;
  localparam int SHORT_FRAME_BYTES = 8;
  localparam logic [15:0] SYNC_WORD = 16'h0B77;

  // Reason codes reported with each frame decision.
  localparam logic [2:0] R_CONVSYNC = 3'd0;
  localparam logic [2:0] R_SHORT    = 3'd1;
  localparam logic [2:0] R_NO_SYNC  = 3'd2;
  localparam logic [2:0] R_RSVD     = 3'd3;
  localparam logic [2:0] R_DEP      = 3'd4;
  localparam logic [2:0] R_SIX_BLK  = 3'd5;
  localparam logic [2:0] R_CUT      = 3'd6;

  // Header field phases, in bit stream order.
  localparam logic [5:0] P_SYNC     = 6'd0;
  localparam logic [5:0] P_STRM     = 6'd1;
  localparam logic [5:0] P_SUBID    = 6'd2;
  localparam logic [5:0] P_FRMSIZ   = 6'd3;
  localparam logic [5:0] P_FSCOD    = 6'd4;
  localparam logic [5:0] P_NUMBLK   = 6'd5;
  localparam logic [5:0] P_ACMOD    = 6'd6;
  localparam logic [5:0] P_LFE      = 6'd7;
  localparam logic [5:0] P_DIALN    = 6'd8;
  localparam logic [5:0] P_COMPRE   = 6'd9;
  localparam logic [5:0] P_COMPR    = 6'd10;
  localparam logic [5:0] P_DIALN2   = 6'd11;
  localparam logic [5:0] P_COMPR2E  = 6'd12;
  localparam logic [5:0] P_COMPR2   = 6'd13;
  localparam logic [5:0] P_MIXE     = 6'd14;
  localparam logic [5:0] P_DMIX     = 6'd15;
  localparam logic [5:0] P_LTRT     = 6'd16;
  localparam logic [5:0] P_SURMIX   = 6'd17;
  localparam logic [5:0] P_LFEMIXE  = 6'd18;
  localparam logic [5:0] P_LFEMIX   = 6'd19;
  localparam logic [5:0] P_PGMSCLE  = 6'd20;
  localparam logic [5:0] P_PGMSCL   = 6'd21;
  localparam logic [5:0] P_EXTPGME  = 6'd22;
  localparam logic [5:0] P_EXTPGM   = 6'd23;
  localparam logic [5:0] P_MIXDEF   = 6'd24;
  localparam logic [5:0] P_MIX1     = 6'd25;
  localparam logic [5:0] P_MIX2     = 6'd26;
  localparam logic [5:0] P_MIXLEN   = 6'd27;
  localparam logic [5:0] P_MIXDATA  = 6'd28;
  localparam logic [5:0] P_PAIRE    = 6'd29;
  localparam logic [5:0] P_PAIR     = 6'd30;
  localparam logic [5:0] P_FRMMIXE  = 6'd31;
  localparam logic [5:0] P_BLKMIXE  = 6'd32;
  localparam logic [5:0] P_BLKMIX   = 6'd33;
  localparam logic [5:0] P_INFOE    = 6'd34;
  localparam logic [5:0] P_INFO5    = 6'd35;
  localparam logic [5:0] P_INFO2    = 6'd36;
  localparam logic [5:0] P_INFO6    = 6'd37;
  localparam logic [5:0] P_INFOCHE  = 6'd38;
  localparam logic [5:0] P_INFOCH   = 6'd39;
  localparam logic [5:0] P_FSADJ    = 6'd40;
  localparam logic [5:0] P_CONVSYNC = 6'd41;
  localparam logic [5:0] P_DONE     = 6'd42;

  // One bit from the byte serializer to the parser.
  typedef struct packed {
    logic valid;
    logic data;
    logic drained;
  } ser_out_t;

  // Bit feed and frame clear into the parser.
  typedef struct packed {
    logic valid;
    logic data;
    logic clear;
  } bit_feed_t;

  // Decision held by the parser.
  typedef struct packed {
    logic       decided;
    logic       start;
    logic [2:0] reason;
  } parse_status_t;

  function automatic logic [8:0] phase_len(input logic [5:0] p);
    case (p)
      P_SYNC:     return 9'd16;
      P_STRM:     return 9'd2;
      P_SUBID:    return 9'd3;
      P_FRMSIZ:   return 9'd11;
      P_FSCOD:    return 9'd2;
      P_NUMBLK:   return 9'd2;
      P_ACMOD:    return 9'd3;
      P_LFE:      return 9'd1;
      P_DIALN:    return 9'd10;
      P_COMPRE:   return 9'd1;
      P_COMPR:    return 9'd8;
      P_DIALN2:   return 9'd5;
      P_COMPR2E:  return 9'd1;
      P_COMPR2:   return 9'd8;
      P_MIXE:     return 9'd1;
      P_DMIX:     return 9'd2;
      P_LTRT:     return 9'd6;
      P_SURMIX:   return 9'd6;
      P_LFEMIXE:  return 9'd1;
      P_LFEMIX:   return 9'd5;
      P_PGMSCLE:  return 9'd1;
      P_PGMSCL:   return 9'd6;
      P_EXTPGME:  return 9'd1;
      P_EXTPGM:   return 9'd6;
      P_MIXDEF:   return 9'd2;
      P_MIX1:     return 9'd5;
      P_MIX2:     return 9'd12;
      P_MIXLEN:   return 9'd5;
      P_MIXDATA:  return 9'd16;
      P_PAIRE:    return 9'd1;
      P_PAIR:     return 9'd14;
      P_FRMMIXE:  return 9'd1;
      P_BLKMIXE:  return 9'd1;
      P_BLKMIX:   return 9'd5;
      P_INFOE:    return 9'd1;
      P_INFO5:    return 9'd5;
      P_INFO2:    return 9'd4;
      P_INFO6:    return 9'd2;
      P_INFOCHE:  return 9'd1;
      P_INFOCH:   return 9'd8;
      P_FSADJ:    return 9'd1;
      P_CONVSYNC: return 9'd1;
      default:    return 9'd1;
    endcase
  endfunction

  // Whether a field is present for the channel mode, LFE flag and rate code.
  function automatic logic phase_applies(input logic [5:0] p, input logic [2:0] m,
                                         input logic lfe, input logic [1:0] rate);
    case (p)
      P_DIALN2, P_COMPR2E, P_COMPR2: return m == 3'd0;
      P_DMIX:                        return m > 3'd2;
      P_LTRT:                        return m[0] && (m > 3'd2);
      P_SURMIX:                      return m[2];
      P_LFEMIXE, P_LFEMIX:           return lfe;
      P_PAIRE, P_PAIR:               return m < 3'd2;
      P_INFO2:                       return m == 3'd2;
      P_INFO6:                       return m >= 3'd6;
      P_FSADJ:                       return rate != 2'd3;
      default:                       return 1'b1;
    endcase
  endfunction

  // First present field at or after p; at most five absent fields in a row.
  function automatic logic [5:0] skip_phase(input logic [5:0] p, input logic [2:0] m,
                                            input logic lfe, input logic [1:0] rate);
    logic [5:0] q;
    q = p;
    for (int i = 0; i < 8; i++) begin
      if (q < P_DONE && !phase_applies(q, m, lfe, rate)) begin
        q = q + 6'd1;
      end
    end
    return q;
  endfunction

  function automatic logic [2:0] blocks_for(input logic [1:0] code);
    case (code)
      2'd0:    return 3'd1;
      2'd1:    return 3'd2;
      2'd2:    return 3'd3;
      default: return 3'd6;
    endcase
  endfunction

endpackage

// ===== hw/rtl/eac3_aus_if.sv =====
// Valid/ready channel interfaces for frame bytes and frame decisions.
interface eac3_aus_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface eac3_aus_out_if;
  logic       valid;
  logic       ready;
  logic       starts_access_unit;
  logic [2:0] reason_code;

  modport source (output valid, output starts_access_unit, output reason_code, input ready);
  modport sink (input valid, input starts_access_unit, input reason_code, output ready);
endinterface

// ===== hw/rtl/eac3_aus_byte_ser.sv =====
// Byte serializer: shifts one loaded byte out MSB first, one bit per cycle.
module eac3_aus_byte_ser
  import eac3_aus_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic        release_byte,
  input  logic [7:0]  byte_in,
  output logic        busy,
  output ser_out_t    ser_o
);

  localparam int CNT_W = $clog2(BYTE_W + 1);

  logic [BYTE_W-1:0] sh_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              bit_cyc;

  assign bit_cyc = busy_r && (cnt_r != CNT_W'(BYTE_W));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (release_byte) begin
      busy_r <= 1'b0;
    end else if (bit_cyc) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh_r <= byte_in;
    end else if (bit_cyc) begin
      sh_r <= {sh_r[BYTE_W-2:0], 1'b0};
    end
  end

  assign busy          = busy_r;
  assign ser_o.valid   = bit_cyc;
  assign ser_o.data    = sh_r[BYTE_W-1];
  assign ser_o.drained = busy_r && (cnt_r == CNT_W'(BYTE_W));

endmodule

// ===== hw/rtl/eac3_aus_bit_parser.sv =====
// Bit-serial header parser: walks the header fields one bit per cycle while fed.
module eac3_aus_bit_parser
  import eac3_aus_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  bit_feed_t     feed_i,
  output parse_status_t status_o
);

  logic [5:0]  phase_r, phase_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  strm_r, strm_nxt;
  logic [2:0]  acmod_r, acmod_nxt;
  logic        lfe_r, lfe_nxt;
  logic [1:0]  fscod_r, fscod_nxt;
  logic [2:0]  blk_r, blk_nxt;
  logic [2:0]  loop_r, loop_nxt;
  logic        decided_r, decided_nxt;
  logic        start_r, start_nxt;
  logic [2:0]  reason_r, reason_nxt;

  logic [15:0] v;
  logic [2:0]  pairs;
  logic [2:0]  nblk;
  logic [2:0]  li1;
  logic        do_enter, do_loop, do_dec, dec_start, mixlen;
  logic [5:0]  tgt, lp_first, lp_after, entered;
  logic [2:0]  lp_n, dec_reason;

  assign v       = {acc_r[14:0], feed_i.data};
  assign pairs   = (acmod_r != 3'd0) ? 3'd1 : 3'd2;
  assign nblk    = (fscod_r == 2'd3) ? 3'd6 : blocks_for(v[1:0]);
  assign li1     = loop_r + 3'd1;
  assign entered = skip_phase(tgt, acmod_r, lfe_r, fscod_r);

  // Field completion: choose the next field, a loop step, or a decision.
  always_comb begin
    do_enter   = 1'b0;
    do_loop    = 1'b0;
    do_dec     = 1'b0;
    dec_start  = 1'b0;
    dec_reason = R_CONVSYNC;
    mixlen     = 1'b0;
    tgt        = P_DONE;
    lp_first   = P_DONE;
    lp_after   = P_DONE;
    lp_n       = pairs;
    strm_nxt   = strm_r;
    acmod_nxt  = acmod_r;
    lfe_nxt    = lfe_r;
    fscod_nxt  = fscod_r;
    blk_nxt    = blk_r;
    case (phase_r)
      P_SYNC: begin
        if (v != SYNC_WORD) begin
          do_dec = 1'b1; dec_reason = R_NO_SYNC; dec_start = 1'b1;
        end else begin
          do_enter = 1'b1; tgt = P_STRM;
        end
      end
      P_STRM: begin
        strm_nxt = v[1:0]; do_enter = 1'b1; tgt = P_SUBID;
      end
      P_SUBID: begin
        if (strm_r == 2'd3) begin
          do_dec = 1'b1; dec_reason = R_RSVD; dec_start = 1'b1;
        end else if (strm_r == 2'd1 || v != 16'd0) begin
          do_dec = 1'b1; dec_reason = R_DEP; dec_start = 1'b0;
        end else begin
          do_enter = 1'b1; tgt = P_FRMSIZ;
        end
      end
      P_FRMSIZ: begin
        do_enter = 1'b1; tgt = P_FSCOD;
      end
      P_FSCOD: begin
        fscod_nxt = v[1:0]; do_enter = 1'b1; tgt = P_NUMBLK;
      end
      P_NUMBLK: begin
        blk_nxt = nblk;
        if (nblk == 3'd6 || strm_r == 2'd2) begin
          do_dec = 1'b1; dec_reason = R_SIX_BLK; dec_start = 1'b1;
        end else begin
          do_enter = 1'b1; tgt = P_ACMOD;
        end
      end
      P_ACMOD: begin
        acmod_nxt = v[2:0]; do_enter = 1'b1; tgt = P_LFE;
      end
      P_LFE: begin
        lfe_nxt = v[0]; do_enter = 1'b1; tgt = P_DIALN;
      end
      P_DIALN: begin
        do_enter = 1'b1; tgt = P_COMPRE;
      end
      P_COMPRE: begin
        do_enter = 1'b1; tgt = v[0] ? P_COMPR : P_DIALN2;
      end
      P_COMPR: begin
        do_enter = 1'b1; tgt = P_DIALN2;
      end
      P_DIALN2: begin
        do_enter = 1'b1; tgt = P_COMPR2E;
      end
      P_COMPR2E: begin
        do_enter = 1'b1; tgt = v[0] ? P_COMPR2 : P_MIXE;
      end
      P_COMPR2: begin
        do_enter = 1'b1; tgt = P_MIXE;
      end
      P_MIXE: begin
        do_enter = 1'b1; tgt = v[0] ? P_DMIX : P_INFOE;
      end
      P_DMIX: begin
        do_enter = 1'b1; tgt = P_LTRT;
      end
      P_LTRT: begin
        do_enter = 1'b1; tgt = P_SURMIX;
      end
      P_SURMIX: begin
        do_enter = 1'b1; tgt = P_LFEMIXE;
      end
      P_LFEMIXE: begin
        do_enter = 1'b1; tgt = v[0] ? P_LFEMIX : P_PGMSCLE;
      end
      P_LFEMIX: begin
        do_enter = 1'b1; tgt = P_PGMSCLE;
      end
      P_PGMSCLE: begin
        do_enter = 1'b1;
        if (v[0]) begin
          tgt = P_PGMSCL;
        end else begin
          do_loop = 1'b1; lp_first = P_PGMSCLE; lp_after = P_EXTPGME;
        end
      end
      P_PGMSCL: begin
        do_enter = 1'b1; do_loop = 1'b1; lp_first = P_PGMSCLE; lp_after = P_EXTPGME;
      end
      P_EXTPGME: begin
        do_enter = 1'b1; tgt = v[0] ? P_EXTPGM : P_MIXDEF;
      end
      P_EXTPGM: begin
        do_enter = 1'b1; tgt = P_MIXDEF;
      end
      P_MIXDEF: begin
        do_enter = 1'b1;
        case (v[1:0])
          2'd1:    tgt = P_MIX1;
          2'd2:    tgt = P_MIX2;
          2'd3:    tgt = P_MIXLEN;
          default: tgt = P_PAIRE;
        endcase
      end
      P_MIX1, P_MIX2, P_MIXDATA: begin
        do_enter = 1'b1; tgt = P_PAIRE;
      end
      P_MIXLEN: begin
        do_enter = 1'b1; tgt = P_MIXDATA; mixlen = 1'b1;
      end
      P_PAIRE: begin
        do_enter = 1'b1;
        if (v[0]) begin
          tgt = P_PAIR;
        end else begin
          do_loop = 1'b1; lp_first = P_PAIRE; lp_after = P_FRMMIXE;
        end
      end
      P_PAIR: begin
        do_enter = 1'b1; do_loop = 1'b1; lp_first = P_PAIRE; lp_after = P_FRMMIXE;
      end
      P_FRMMIXE: begin
        do_enter = 1'b1;
        if (!v[0]) begin
          tgt = P_INFOE;
        end else begin
          tgt = (blk_r == 3'd1) ? P_BLKMIX : P_BLKMIXE;
        end
      end
      P_BLKMIXE: begin
        do_enter = 1'b1; lp_n = blk_r;
        if (v[0]) begin
          tgt = P_BLKMIX;
        end else begin
          do_loop = 1'b1; lp_first = P_BLKMIXE; lp_after = P_INFOE;
        end
      end
      P_BLKMIX: begin
        do_enter = 1'b1; do_loop = 1'b1; lp_n = blk_r; lp_after = P_INFOE;
        lp_first = (blk_r == 3'd1) ? P_BLKMIX : P_BLKMIXE;
      end
      P_INFOE: begin
        do_enter = 1'b1; tgt = v[0] ? P_INFO5 : P_CONVSYNC;
      end
      P_INFO5: begin
        do_enter = 1'b1; tgt = P_INFO2;
      end
      P_INFO2: begin
        do_enter = 1'b1; tgt = P_INFO6;
      end
      P_INFO6: begin
        do_enter = 1'b1; tgt = P_INFOCHE;
      end
      P_INFOCHE: begin
        do_enter = 1'b1;
        if (v[0]) begin
          tgt = P_INFOCH;
        end else begin
          do_loop = 1'b1; lp_first = P_INFOCHE; lp_after = P_FSADJ;
        end
      end
      P_INFOCH: begin
        do_enter = 1'b1; do_loop = 1'b1; lp_first = P_INFOCHE; lp_after = P_FSADJ;
      end
      P_FSADJ: begin
        do_enter = 1'b1; tgt = P_CONVSYNC;
      end
      P_CONVSYNC: begin
        do_dec = 1'b1; dec_reason = R_CONVSYNC; dec_start = v[0];
      end
      default: begin
        do_enter = 1'b1; tgt = P_DONE;
      end
    endcase
    // Loop counters step before the next field is chosen.
    loop_nxt = loop_r;
    if (do_loop) begin
      if (li1 < lp_n) begin
        tgt      = lp_first;
        loop_nxt = li1;
      end else begin
        tgt      = lp_after;
        loop_nxt = 3'd0;
      end
    end
  end

  // State update for one bit, or a frame clear.
  always_comb begin
    phase_nxt   = phase_r;
    rem_nxt     = rem_r;
    acc_nxt     = acc_r;
    decided_nxt = decided_r;
    start_nxt   = start_r;
    reason_nxt  = reason_r;
    if (feed_i.valid && !decided_r && phase_r < P_DONE) begin
      acc_nxt = v;
      rem_nxt = rem_r - 9'd1;
      if (rem_r == 9'd1) begin
        if (do_dec) begin
          decided_nxt = 1'b1;
          start_nxt   = dec_start;
          reason_nxt  = dec_reason;
          phase_nxt   = P_DONE;
        end else if (do_enter) begin
          phase_nxt = entered;
          acc_nxt   = 16'd0;
          rem_nxt   = mixlen ? (({4'd0, v[4:0]} + 9'd2) << 3) : phase_len(entered);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || feed_i.clear) begin
      phase_r   <= P_SYNC;
      rem_r     <= phase_len(P_SYNC);
      acc_r     <= 16'd0;
      strm_r    <= 2'd0;
      acmod_r   <= 3'd0;
      lfe_r     <= 1'b0;
      fscod_r   <= 2'd0;
      blk_r     <= 3'd6;
      loop_r    <= 3'd0;
      decided_r <= 1'b0;
      start_r   <= 1'b0;
      reason_r  <= R_CONVSYNC;
    end else begin
      phase_r   <= phase_nxt;
      rem_r     <= rem_nxt;
      acc_r     <= acc_nxt;
      decided_r <= decided_nxt;
      start_r   <= start_nxt;
      reason_r  <= reason_nxt;
      if (feed_i.valid && !decided_r && phase_r < P_DONE && rem_r == 9'd1) begin
        strm_r  <= strm_nxt;
        acmod_r <= acmod_nxt;
        lfe_r   <= lfe_nxt;
        fscod_r <= fscod_nxt;
        blk_r   <= blk_nxt;
        loop_r  <= loop_nxt;
      end
    end
  end

  assign status_o.decided = decided_r;
  assign status_o.start   = start_r;
  assign status_o.reason  = reason_r;

endmodule

// ===== hw/rtl/eac3_access_unit_start_check.sv =====
// Top level: E-AC-3 access unit start checker, byte in, one decision per frame out.
// Each byte has an accept edge, bit cycles in which the serializer feeds one bit
// per cycle to the bit-serial parser in the header window, and a closing cycle.
// A frame decision is written to the output register in the closing cycle of the
// byte that carries frame_end; that cycle waits while an older decision is not taken.
// Reset (rst_n low, synchronous) empties the output register and returns the
// parser to the sync word field with a zero byte count.
module eac3_access_unit_start_check
  import eac3_aus_pkg::*;
#(
  parameter int HEADER_WINDOW_BYTES = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  eac3_aus_in_if.sink           in_ch,
  eac3_aus_out_if.source        out_ch
);

  // The byte counter only needs to reach the window size, where it saturates.
  localparam int BC_W = $clog2(HEADER_WINDOW_BYTES + 1);

  logic [BC_W-1:0] bc_r;
  logic            take_r;
  logic            last_r;
  logic            out_valid_r;
  logic            out_start_r;
  logic [2:0]      out_reason_r;

  logic            ser_busy;
  ser_out_t        ser;
  bit_feed_t       feed;
  parse_status_t   status;
  logic            accept;
  logic            close_byte;
  logic            out_free;

  // A new byte is taken whenever the serializer is empty; a pending decision in
  // the output register holds up input only by stalling a frame's closing cycle.
  assign in_ch.ready = !ser_busy;
  assign accept      = in_ch.valid && !ser_busy;

  // The closing cycle of a frame's last byte needs a free output slot.
  assign out_free   = !out_valid_r || out_ch.ready;
  assign close_byte = ser.drained && (!last_r || out_free);

  eac3_aus_byte_ser u_ser (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept),
    .release_byte (close_byte),
    .byte_in      (in_ch.frame_byte),
    .busy         (ser_busy),
    .ser_o        (ser)
  );

  // Bytes past the header window are neither counted nor passed to the parser.
  assign feed.valid = ser.valid && take_r;
  assign feed.data  = ser.data;
  assign feed.clear = close_byte && last_r;

  eac3_aus_bit_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .feed_i   (feed),
    .status_o (status)
  );

  // The byte count is advanced at accept time, so by the closing cycle it
  // already includes the current byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r   <= '0;
      take_r <= 1'b0;
      last_r <= 1'b0;
    end else if (accept) begin
      last_r <= in_ch.frame_end;
      take_r <= bc_r < BC_W'(HEADER_WINDOW_BYTES);
      if (bc_r < BC_W'(HEADER_WINDOW_BYTES)) begin
        bc_r <= bc_r + BC_W'(1);
      end
    end else if (close_byte && last_r) begin
      bc_r <= '0;
    end
  end

  // Output register. A short frame wins over any parser decision, and a
  // header that never reached its convsync bit counts as a start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (close_byte && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (close_byte && last_r) begin
      if (bc_r < BC_W'(SHORT_FRAME_BYTES)) begin
        out_start_r  <= 1'b1;
        out_reason_r <= R_SHORT;
      end else if (status.decided) begin
        out_start_r  <= status.start;
        out_reason_r <= status.reason;
      end else begin
        out_start_r  <= 1'b1;
        out_reason_r <= R_CUT;
      end
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.starts_access_unit = out_start_r;
  assign out_ch.reason_code        = out_reason_r;

endmodule
